[rtl/sfd_pkg.sv]
// constants, types and helpers shared by the sbus frame decoder files
package sfd_pkg;

  localparam int CHANNEL_COUNT  = 16;
  localparam int BITS_PER_VALUE = 11;
  localparam int FRAME_LENGTH   = 25;

  localparam int BYTE_W     = 8;
  localparam int POS_W      = 5;
  localparam int INDEX_W    = 4;
  localparam int DATA_BYTES = FRAME_LENGTH - 3;
  localparam int FRAME_BITS = DATA_BYTES * BYTE_W;
  localparam int FLAG_POS   = DATA_BYTES + 1;
  localparam int TAIL_POS   = DATA_BYTES + 2;

  localparam logic [BYTE_W-1:0] HEADER_A = 8'h0F;
  localparam logic [BYTE_W-1:0] HEADER_B = 8'h8F;
  localparam logic [BYTE_W-1:0] TAIL_A   = 8'h00;
  localparam logic [BYTE_W-1:0] TAIL_B   = 8'h04;
  localparam logic [BYTE_W-1:0] TAIL_C   = 8'h14;
  localparam logic [BYTE_W-1:0] TAIL_D   = 8'h24;
  localparam logic [BYTE_W-1:0] TAIL_E   = 8'h34;

  localparam logic [POS_W-1:0]   POS_IDLE   = POS_W'(0);
  localparam logic [POS_W-1:0]   POS_FLAG   = POS_W'(FLAG_POS);
  localparam logic [POS_W-1:0]   POS_TAIL   = POS_W'(TAIL_POS);
  localparam logic [POS_W-1:0]   POS_LASTD  = POS_W'(DATA_BYTES);
  localparam logic [POS_W-1:0]   POS_END    = POS_W'(FRAME_LENGTH);
  localparam logic [INDEX_W-1:0] LAST_INDEX = INDEX_W'(CHANNEL_COUNT - 1);

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  function automatic logic header_ok(input logic [BYTE_W-1:0] b);
    return (b == HEADER_A) || (b == HEADER_B);
  endfunction

  function automatic logic tail_ok(input logic [BYTE_W-1:0] b);
    return (b == TAIL_A) || (b == TAIL_B) || (b == TAIL_C) || (b == TAIL_D) ||
           (b == TAIL_E);
  endfunction

endpackage

[rtl/sfd_rx_if.sv]
// byte channel into the decoder
interface sfd_rx_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/sfd_ch_if.sv]
// channel value channel out of the decoder
interface sfd_ch_if;
  logic                               valid;
  logic                               ready;
  logic [sfd_pkg::BITS_PER_VALUE-1:0] channel_value;
  logic [sfd_pkg::INDEX_W-1:0]        channel_index;
  logic                               last_channel;

  modport source (output valid, output channel_value, output channel_index,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_value, input channel_index,
                  input last_channel, output ready);
endinterface

[rtl/sbus_frame_decoder.sv]
// sbus frame decoder: collects 25-byte frames and emits 16 channel values
// a good tail byte sets the state register to emit; the first channel value then passes through the output register
// throughput: one byte per cycle while collecting; after a tail, 16 values one per cycle
//   while chan.ready allows and no byte is taken, set by the 11-bit digit shift of the frame register
// reset (synchronous, rst high): awaits a header byte, no output pending
// the frame register holds no reset value; every frame rewrites it before the tail
module sbus_frame_decoder (
  input  logic    clk,
  input  logic    rst,
  sfd_rx_if.sink  rx,
  sfd_ch_if.source chan
);
  import sfd_pkg::*;

  state_t                    state, state_next;
  logic [POS_W-1:0]          byte_position;
  logic [FRAME_BITS-1:0]     frame;
  logic [INDEX_W-1:0]        ch_count;
  logic                      out_valid;
  logic [BITS_PER_VALUE-1:0] out_value;
  logic [INDEX_W-1:0]        out_index;
  logic                      out_last;

  logic rx_take;
  logic load;
  logic rx_ready;
  logic last_load;
  logic good_tail;

  assign rx_take   = rx.valid && rx_ready;
  assign last_load = load && (ch_count == LAST_INDEX);
  assign good_tail = rx_take && (byte_position == POS_TAIL) && tail_ok(rx.rx_byte);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (good_tail) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_load) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    rx_ready = 1'b0;
    load     = 1'b0;
    case (state)
      ST_COLLECT: rx_ready = 1'b1;
      ST_EMIT:    load     = !out_valid || chan.ready;
      default: begin
        rx_ready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_COLLECT;
      byte_position <= POS_IDLE;
      ch_count      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (rx_take) begin
        if (byte_position == POS_IDLE || byte_position >= POS_END) begin
          byte_position <= header_ok(rx.rx_byte) ? POS_W'(1) : POS_IDLE;
        end else if (byte_position == POS_TAIL) begin
          byte_position <= POS_IDLE;
        end else begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
      if (good_tail) begin
        ch_count <= '0;
      end else if (load) begin
        ch_count <= ch_count + INDEX_W'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame shift register: bytes enter at the top, values leave 11 bits at a time
  always_ff @(posedge clk) begin
    if (rx_take && byte_position != POS_IDLE && byte_position <= POS_LASTD) begin
      frame <= {rx.rx_byte, frame[FRAME_BITS-1:BYTE_W]};
    end else if (load) begin
      frame <= {{BITS_PER_VALUE{1'b0}}, frame[FRAME_BITS-1:BITS_PER_VALUE]};
    end
    if (load) begin
      out_value <= frame[BITS_PER_VALUE-1:0];
      out_index <= ch_count;
      out_last  <= (ch_count == LAST_INDEX);
    end
  end

  assign rx.ready           = rx_ready;
  assign chan.valid         = out_valid;
  assign chan.channel_value = out_value;
  assign chan.channel_index = out_index;
  assign chan.last_channel  = out_last;

`ifndef SYNTH
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    chan.valid && chan.last_channel |-> chan.channel_index == LAST_INDEX)
    else $error("last channel flag on wrong index");

  a_emit_idle_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> byte_position == POS_IDLE)
    else $error("frame position moved during emission");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    last_load |=> state == ST_COLLECT && chan.valid && chan.last_channel)
    else $error("emission did not end after last channel");

  a_tail_starts: assert property (@(posedge clk) disable iff (rst)
    good_tail |=> state == ST_EMIT && ch_count == '0)
    else $error("good tail did not start emission");
`endif

endmodule
